FILE: design/tsrt_pkg.sv
// Shared constants, codes and result control type for the tagged stack.
package tsrt_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;
    localparam int TAG_BITS_DEF  = 8;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_LIST   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   has_entry;
        logic [COUNT_BITS-1:0]  count;
        logic                   last;
    } res_ctl_t;

endpackage

FILE: design/tsrt_in_if.sv
// Command channel: op, payload and category with valid/ready.
interface tsrt_in_if #(
    parameter int DATA_BITS = tsrt_pkg::DATA_BITS_DEF,
    parameter int TAG_BITS  = tsrt_pkg::TAG_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [tsrt_pkg::OP_BITS-1:0]  op;
    logic [DATA_BITS-1:0]          payload;
    logic [TAG_BITS-1:0]           category;

    modport source (output valid, output op, output payload, output category, input ready);
    modport sink   (input valid, input op, input payload, input category, output ready);
endinterface

FILE: design/tsrt_out_if.sv
// Result channel: status, entry fields, count and last with valid/ready.
interface tsrt_out_if #(
    parameter int DATA_BITS = tsrt_pkg::DATA_BITS_DEF,
    parameter int TAG_BITS  = tsrt_pkg::TAG_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [tsrt_pkg::STATUS_BITS-1:0] status;
    logic                             has_entry;
    logic [DATA_BITS-1:0]             entry_data;
    logic [TAG_BITS-1:0]              entry_tag;
    logic [tsrt_pkg::COUNT_BITS-1:0]  count;
    logic                             last;

    modport source (
        output valid, output status, output has_entry, output entry_data,
        output entry_tag, output count, output last, input ready
    );
    modport sink (
        input valid, input status, input has_entry, input entry_data,
        input entry_tag, input count, input last, output ready
    );
endinterface

FILE: design/tsrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/tsrt_seq.sv
// Sequencer: walks the entry RAM one slot per cycle while the output stage is free, with a shared tag compare.
module tsrt_seq #(
    parameter int DEPTH     = tsrt_pkg::DEPTH_DEF,
    parameter int DATA_BITS = tsrt_pkg::DATA_BITS_DEF,
    parameter int TAG_BITS  = tsrt_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tsrt_pkg::OP_BITS-1:0]  op,
    input  logic [DATA_BITS-1:0]          payload,
    input  logic [TAG_BITS-1:0]           category,
    input  logic                          out_free,
    output logic                          res_valid,
    output tsrt_pkg::res_ctl_t            res_ctl,
    output logic [DATA_BITS-1:0]          res_data,
    output logic [TAG_BITS-1:0]           res_tag,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [DATA_BITS+TAG_BITS-1:0] ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [DATA_BITS+TAG_BITS-1:0] ram_rdata
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POP   = 7'b0000010,
        S_COUNT = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_PACK  = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_LIST  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    wr_reg, wr_next;
    logic [CNT_W-1:0]    match_reg, match_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    logic [DATA_BITS-1:0] rd_data;
    logic [TAG_BITS-1:0]  rd_tag;
    logic                 hit;
    logic                 at_bottom;
    logic [IDX_W-1:0]     top_idx;
    logic [CNT_W-1:0]     kept;
    logic                 step;

    assign rd_data   = ram_rdata[DATA_BITS-1:0];
    assign rd_tag    = ram_rdata[DATA_BITS +: TAG_BITS];
    assign hit       = (rd_tag == tag_reg);
    assign at_bottom = (idx_reg == '0);
    assign top_idx   = IDX_W'(fill_reg - 1'b1);
    assign kept      = fill_reg - match_reg;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign ram_raddr = idx_next;

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        fill_next         = fill_reg;
        wr_next           = wr_reg;
        match_next        = match_reg;
        tag_next          = tag_reg;
        ram_we            = 1'b0;
        ram_waddr         = IDX_W'(wr_reg);
        ram_wdata         = ram_rdata;
        res_valid         = 1'b0;
        res_ctl.status    = tsrt_pkg::ST_OK;
        res_ctl.has_entry = 1'b0;
        res_ctl.count     = tsrt_pkg::COUNT_BITS'(fill_reg);
        res_ctl.last      = 1'b1;
        res_data          = '0;
        res_tag           = '0;
        step              = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    res_valid = 1'b1;
                    if (op == tsrt_pkg::OP_PUSH)
                    begin
                        if (fill_reg == CNT_W'(DEPTH))
                        begin
                            res_ctl.status = tsrt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(fill_reg);
                            ram_wdata = {category, payload};
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else if (op > tsrt_pkg::OP_LIST)
                    begin
                        res_ctl.status = tsrt_pkg::ST_OK;
                    end
                    else if (fill_reg == '0)
                    begin
                        res_ctl.status = tsrt_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        case (op)
                            tsrt_pkg::OP_POP:
                            begin
                                res_valid  = 1'b0;
                                fill_next  = fill_reg - 1'b1;
                                idx_next   = top_idx;
                                state_next = S_POP;
                            end
                            tsrt_pkg::OP_REMOVE:
                            begin
                                res_valid  = 1'b0;
                                tag_next   = category;
                                match_next = '0;
                                idx_next   = top_idx;
                                state_next = S_COUNT;
                            end
                            tsrt_pkg::OP_LIST:
                            begin
                                res_valid  = 1'b0;
                                idx_next   = top_idx;
                                state_next = S_LIST;
                            end
                            tsrt_pkg::OP_CLEAR:
                            begin
                                fill_next = '0;
                            end
                            default:
                            begin
                                fill_next = fill_reg;
                            end
                        endcase
                    end
                    res_ctl.count = tsrt_pkg::COUNT_BITS'(fill_next);
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    res_valid         = 1'b1;
                    res_ctl.has_entry = 1'b1;
                    res_data          = rd_data;
                    res_tag           = rd_tag;
                    state_next        = S_IDLE;
                end
            end
            S_COUNT:
            begin
                if (hit)
                begin
                    match_next = match_reg + 1'b1;
                end
                if (at_bottom)
                begin
                    idx_next   = top_idx;
                    state_next = (match_reg == '0 && !hit) ? S_SUM : S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                step = !hit || out_free;
                if (hit && out_free)
                begin
                    res_valid         = 1'b1;
                    res_ctl.has_entry = 1'b1;
                    res_ctl.count     = tsrt_pkg::COUNT_BITS'(kept);
                    res_ctl.last      = 1'b0;
                    res_data          = rd_data;
                    res_tag           = rd_tag;
                end
                if (step)
                begin
                    if (at_bottom)
                    begin
                        idx_next   = '0;
                        wr_next    = '0;
                        state_next = S_PACK;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_PACK:
            begin
                if (!hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(wr_reg);
                    ram_wdata = ram_rdata;
                    wr_next   = wr_reg + 1'b1;
                end
                if (idx_reg == top_idx)
                begin
                    fill_next  = kept;
                    state_next = S_SUM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    res_valid         = 1'b1;
                    res_ctl.has_entry = 1'b1;
                    res_ctl.last      = at_bottom;
                    res_data          = rd_data;
                    res_tag           = rd_tag;
                    if (at_bottom)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            wr_reg    <= '0;
            match_reg <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            wr_reg    <= wr_next;
            match_reg <= match_next;
            tag_reg   <= tag_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    a_emit_has_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> match_reg != '0)
        else $error("emit pass without matches");

    a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PACK |-> wr_reg <= CNT_W'(idx_reg))
        else $error("compaction write overtook read");

    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued into busy output stage");
endmodule

FILE: design/tsrt_out.sv
// Output register stage: holds one result transaction until the sink takes it.
module tsrt_out #(
    parameter int DATA_BITS = tsrt_pkg::DATA_BITS_DEF,
    parameter int TAG_BITS  = tsrt_pkg::TAG_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  tsrt_pkg::res_ctl_t   res_ctl,
    input  logic [DATA_BITS-1:0] res_data,
    input  logic [TAG_BITS-1:0]  res_tag,
    output logic                 out_free,
    tsrt_out_if.source           out_ch
);
    logic                 vld_reg;
    tsrt_pkg::res_ctl_t   ctl_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic [TAG_BITS-1:0]  tag_reg;

    assign out_free = !vld_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            ctl_reg  <= res_ctl;
            data_reg <= res_data;
            tag_reg  <= res_tag;
        end
    end

    assign out_ch.valid      = vld_reg;
    assign out_ch.status     = ctl_reg.status;
    assign out_ch.has_entry  = ctl_reg.has_entry;
    assign out_ch.entry_data = data_reg;
    assign out_ch.entry_tag  = tag_reg;
    assign out_ch.count      = ctl_reg.count;
    assign out_ch.last       = ctl_reg.last;
endmodule

FILE: design/tagged_stack_remove_by_tag_top.sv
// Tagged LIFO stack with remove-by-tag: top level.
// in_ch carries one command transaction: op (push, pop, remove by tag, clear,
// list), payload and category. out_ch returns result transactions: status,
// has_entry, entry_data, entry_tag, count after the operation, and last on
// the final result of a command. in_ch.ready is high only when the sequencer
// is idle and the output register can take a result.
// Operation flow, n entries held, one RAM read port walking one slot per cycle
// while out_ch is not stalled:
//   push, clear, unused op, empty stack: result computed at once and registered
//   pop: one RAM read, then the result
//   list: one result per entry, top to bottom
//   remove by tag, no match: a count pass, then the summary result
//   remove by tag, with matches: count, emit and compact passes, then summary
// A stalled out_ch holds its result and freezes the list and emit walks in
// place; no transaction is lost. Reset empties the stack at once; the entry
// RAM is not cleared and needs no sweep.
module tagged_stack_remove_by_tag_top #(
    parameter int DEPTH     = tsrt_pkg::DEPTH_DEF,
    parameter int DATA_BITS = tsrt_pkg::DATA_BITS_DEF,
    parameter int TAG_BITS  = tsrt_pkg::TAG_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tsrt_in_if.sink     in_ch,
    tsrt_out_if.source  out_ch
);
    localparam int IDX_W = $clog2(DEPTH);

    logic                          out_free;
    logic                          res_valid;
    tsrt_pkg::res_ctl_t            res_ctl;
    logic [DATA_BITS-1:0]          res_data;
    logic [TAG_BITS-1:0]           res_tag;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [DATA_BITS+TAG_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    logic [DATA_BITS+TAG_BITS-1:0] ram_rdata;
    logic                          in_ready;

    assign in_ch.ready = in_ready;

    tsrt_ram #(
        .WIDTH (DATA_BITS + TAG_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsrt_seq #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .op        (in_ch.op),
        .payload   (in_ch.payload),
        .category  (in_ch.category),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_ctl   (res_ctl),
        .res_data  (res_data),
        .res_tag   (res_tag),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tsrt_out #(
        .DATA_BITS (DATA_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ctl   (res_ctl),
        .res_data  (res_data),
        .res_tag   (res_tag),
        .out_free  (out_free),
        .out_ch    (out_ch)
    );
endmodule
